// File: hw/rtl/tnlp_pkg.sv
// ----------------------------------------------------------------------------
// tnlp_pkg
// Shared types, constants and helper functions of the next-line predictor.
// ----------------------------------------------------------------------------
package tnlp_pkg;

  localparam int unsigned AddrW        = 48;
  localparam int unsigned TagW         = 46;
  localparam int unsigned LslW         = 4;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned CfgDataW     = 4;
  localparam int unsigned IndexBitsDef = 10;
  localparam int unsigned LslMin       = 2;
  localparam int unsigned LslMax       = 8;
  localparam int unsigned LslRst       = 6;

  localparam logic [CfgIdxW-1:0] CfgStraightLine = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgLineSizeLog2 = CfgIdxW'(1);

  localparam logic KindFetch   = 1'b0;
  localparam logic KindPredict = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_EVAL
  } tnlp_state_e;

  // controller to datapath
  typedef struct packed {
    logic clr_wr;
    logic capture;
    logic rd_en;
    logic eval_fetch;
    logic load_out;
  } tnlp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
    logic kind;
    logic out_free;
  } tnlp_status_t;

  // line size clamped to the supported range
  function automatic logic [LslW-1:0] eff_shift(input logic [LslW-1:0] lsl);
    logic [LslW-1:0] sh;
    sh = lsl;
    if (lsl < LslW'(LslMin)) sh = LslW'(LslMin);
    if (lsl > LslW'(LslMax)) sh = LslW'(LslMax);
    return sh;
  endfunction

  function automatic logic [TagW-1:0] line_tag(input logic [AddrW-1:0] addr,
                                               input logic [LslW-1:0]  sh);
    logic [AddrW-1:0] shifted;
    shifted = addr >> sh;
    return shifted[TagW-1:0];
  endfunction

endpackage

// File: hw/rtl/tnlp_ctrl.sv
// ----------------------------------------------------------------------------
// tnlp_ctrl
// Sequencer: table clearing after reset, then lookup and evaluate per item.
// ----------------------------------------------------------------------------
module tnlp_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  tnlp_pkg::tnlp_status_t status_i,
  output tnlp_pkg::tnlp_cmd_t    cmd_o
);
  import tnlp_pkg::*;

  tnlp_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_EVAL;
      end
      ST_EVAL: begin
        if (status_i.kind == KindFetch) begin
          cmd_o.eval_fetch = 1'b1;
          state_d          = ST_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

endmodule

// File: hw/rtl/tnlp_datapath.sv
// ----------------------------------------------------------------------------
// tnlp_datapath
// Prediction table, last fetched line, config registers and result register.
// ----------------------------------------------------------------------------
module tnlp_datapath #(
  parameter int unsigned INDEX_BITS = tnlp_pkg::IndexBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [tnlp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tnlp_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          kind_i,
  input  logic [tnlp_pkg::AddrW-1:0]    line_addr_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [tnlp_pkg::AddrW-1:0]    predicted_addr_o,
  output logic                          table_hit_o,
  input  tnlp_pkg::tnlp_cmd_t           cmd_i,
  output tnlp_pkg::tnlp_status_t        status_o
);
  import tnlp_pkg::*;

  localparam int unsigned Depth  = 2 ** INDEX_BITS;
  localparam int unsigned EntryW = TagW + AddrW;

  logic                  straight_q;
  logic [LslW-1:0]       lsl_q;
  logic                  kind_q;
  logic [AddrW-1:0]      addr_q;
  logic [AddrW-1:0]      last_q;
  logic [INDEX_BITS-1:0] clr_cnt_q;
  logic                  out_valid_q;
  logic [AddrW-1:0]      out_addr_q;
  logic                  out_hit_q;

  logic [EntryW-1:0]     mem [Depth];
  logic [EntryW-1:0]     rd_data_q;

  logic [LslW-1:0]       sh;
  logic [AddrW-1:0]      step;
  logic [AddrW-1:0]      look_addr;
  logic [TagW-1:0]       look_tag;
  logic [INDEX_BITS-1:0] look_idx;
  logic [TagW-1:0]       rd_tag;
  logic [AddrW-1:0]      rd_target;
  logic                  tag_match;
  logic [AddrW:0]        seq_sum;
  logic                  is_seq;
  logic                  wr_en;
  logic [INDEX_BITS-1:0] wr_idx;
  logic [EntryW-1:0]     wr_data;

  // configuration registers, always writable
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      straight_q <= 1'b0;
      lsl_q      <= LslW'(LslRst);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgStraightLine: straight_q <= cfg_data_i[0];
        CfgLineSizeLog2: lsl_q      <= cfg_data_i[LslW-1:0];
        default: ;
      endcase
    end
  end

  assign sh        = eff_shift(lsl_q);
  assign step      = AddrW'(1) << sh;
  // fetch trains the entry of the previous line, predict looks up its own line
  assign look_addr = (kind_q == KindPredict) ? addr_q : last_q;
  assign look_tag  = line_tag(look_addr, sh);
  assign look_idx  = look_tag[INDEX_BITS-1:0];
  assign rd_tag    = rd_data_q[EntryW-1:AddrW];
  assign rd_target = rd_data_q[AddrW-1:0];
  assign tag_match = (rd_tag == look_tag);
  assign seq_sum   = {1'b0, last_q} + {1'b0, step};
  assign is_seq    = (seq_sum == {1'b0, addr_q});

  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = look_idx;
    wr_data = {TagW'(0), rd_target};
    if (cmd_i.clr_wr) begin
      wr_en   = 1'b1;
      wr_idx  = clr_cnt_q;
      wr_data = '0;
    end else if (cmd_i.eval_fetch && !straight_q && (last_q != addr_q)) begin
      if (!is_seq) begin
        wr_en   = 1'b1;
        wr_data = {look_tag, addr_q};
      end else if (tag_match) begin
        wr_en   = 1'b1;
        wr_data = {TagW'(0), rd_target};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_idx] <= wr_data;
    if (cmd_i.rd_en) rd_data_q <= mem[look_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      last_q    <= '0;
    end else begin
      if (cmd_i.clr_wr) clr_cnt_q <= clr_cnt_q + INDEX_BITS'(1);
      if (cmd_i.eval_fetch) last_q <= addr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= kind_i;
      addr_q <= line_addr_i;
    end
    if (cmd_i.load_out) begin
      if (!straight_q && tag_match) begin
        out_addr_q <= rd_target;
        out_hit_q  <= 1'b1;
      end else begin
        out_addr_q <= addr_q + step;
        out_hit_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign predicted_addr_o = out_addr_q;
  assign table_hit_o      = out_hit_q;

  assign status_o.clr_done = (clr_cnt_q == {INDEX_BITS{1'b1}});
  assign status_o.kind     = kind_q;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

endmodule

// File: hw/rtl/tagged_next_line_predictor_unit.sv
// ----------------------------------------------------------------------------
// tagged_next_line_predictor_unit
// Direct-mapped next-line predictor with tagged entries.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) carries kind_i and line_addr_i. A
// fetch transaction trains the table on the step from the last fetched line
// and gives no result; a predict transaction gives one result on the output
// channel (out_valid_o / out_stall_i): predicted_addr_o and table_hit_o.
// Each transaction goes through accept, table read and evaluate in turn. A
// predict result is valid in the cycle after evaluation. A new input
// transaction is accepted only once the previous one has left evaluate.
// The result sits in an output register; while the receiver stalls the
// next input is still taken, and a further predict waits in its evaluate
// step until the output register is free.
// After reset all 2**INDEX_BITS table entries are swept to zero, one entry
// per cycle; no input is accepted during the sweep. The config
// port (index 0: straight-line mode, 1: line size log2) is always ready
// and should only be written while the block is idle.
// ----------------------------------------------------------------------------
module tagged_next_line_predictor_unit #(
  parameter int unsigned INDEX_BITS = tnlp_pkg::IndexBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tnlp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tnlp_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          kind_i,
  input  logic [tnlp_pkg::AddrW-1:0]    line_addr_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [tnlp_pkg::AddrW-1:0]    predicted_addr_o,
  output logic                          table_hit_o
);
  import tnlp_pkg::*;

  tnlp_cmd_t    cmd;
  tnlp_status_t status;

  assign cfg_ready_o = 1'b1;

  tnlp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tnlp_datapath #(
    .INDEX_BITS (INDEX_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i & cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .kind_i           (kind_i),
    .line_addr_i      (line_addr_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .predicted_addr_o (predicted_addr_o),
    .table_hit_o      (table_hit_o),
    .cmd_i            (cmd),
    .status_o         (status)
  );

endmodule

// File: bench/tb_tagged_next_line_predictor_unit.sv
// ----------------------------------------------------------------------------
// tb_tagged_next_line_predictor_unit
// Self-checking bench for the tagged next-line predictor. A directed burst
// and constrained-by-hand random fetch/predict streams are driven through the
// valid/stall input channel. The bench keeps its own copy of the direct-mapped
// tag/target table and checks every result transaction in order. The
// configuration changes between phases, only while the block is drained.
// ----------------------------------------------------------------------------
module tb_tagged_next_line_predictor_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import tnlp_pkg::*;

  localparam int unsigned IDX_BITS  = IndexBitsDef;
  localparam int unsigned TBL_DEPTH = 1 << IDX_BITS;
  localparam int unsigned HOLD_LEN  = 300;
  localparam int unsigned N_PHASES  = 9;

  typedef struct packed {
    logic             kind;
    logic [AddrW-1:0] addr;
  } line_req_t;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic             hit;
  } line_pred_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = CfgStraightLine;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic                kind_i      = KindFetch;
  logic [AddrW-1:0]    line_addr_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [AddrW-1:0]    predicted_addr_o;
  logic                table_hit_o;

  tagged_next_line_predictor_unit #(
    .INDEX_BITS(IDX_BITS)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .line_addr_i     (line_addr_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .predicted_addr_o(predicted_addr_o),
    .table_hit_o     (table_hit_o)
  );

  always #6 clk_i = ~clk_i;

  // bench copy of the predictor state
  logic [AddrW-1:0] last_line;
  logic [TagW-1:0]  tag_tbl [TBL_DEPTH];
  logic [AddrW-1:0] tgt_tbl [TBL_DEPTH];
  logic             straight_mode;
  logic [LslW-1:0]  lsl_cfg;

  line_req_t   fetch_stream_q[$];
  line_pred_t  next_line_q[$];
  int unsigned lines_sent    = 0;
  int unsigned lines_taken   = 0;
  int unsigned mismatch_cnt  = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          in_took       = 1'b0;
  bit          hold_kick     = 1'b0;
  bit          hold_ack      = 1'b0;
  int unsigned hold_left     = 0;

  // stimulus generator state
  logic [AddrW-1:0] cur_line;
  logic [AddrW-1:0] hot_lines [16];

  function automatic int unsigned shift_of(input logic [LslW-1:0] lsl);
    if (lsl < LslMin) return LslMin;
    if (lsl > LslMax) return LslMax;
    return int'(lsl);
  endfunction

  function automatic logic [AddrW-1:0] rand_addr();
    return AddrW'({$urandom, $urandom});
  endfunction

  task automatic advance_line_table(input line_req_t req);
    int unsigned     sh;
    int unsigned     ix;
    logic [TagW-1:0] tg;
    line_pred_t      res;
    sh = shift_of(lsl_cfg);
    if (req.kind == KindFetch) begin
      if (req.addr != last_line && !straight_mode) begin
        tg = TagW'(last_line >> sh);
        ix = int'(tg[IDX_BITS-1:0]);
        // sequential only on an exact forward step of one line, no wrap
        if (!(req.addr > last_line && (req.addr - last_line) == (AddrW'(1) << sh))) begin
          tag_tbl[ix] = tg;
          tgt_tbl[ix] = req.addr;
        end else if (tag_tbl[ix] == tg) begin
          tag_tbl[ix] = '0;
        end
      end
      last_line = req.addr;
    end else begin
      tg = TagW'(req.addr >> sh);
      ix = int'(tg[IDX_BITS-1:0]);
      if (!straight_mode && tag_tbl[ix] == tg) begin
        res.addr = tgt_tbl[ix];
        res.hit  = 1'b1;
      end else begin
        res.addr = req.addr + (AddrW'(1) << sh);
        res.hit  = 1'b0;
      end
      next_line_q = {next_line_q, res};
    end
  endtask

  task automatic push_line(input logic kind, input logic [AddrW-1:0] addr);
    line_req_t req;
    req.kind = kind;
    req.addr = addr;
    fetch_stream_q = {fetch_stream_q, req};
    lines_sent++;
  endtask

  task automatic pick_hot_lines();
    int unsigned      sh;
    logic [AddrW-1:0] align;
    logic [AddrW-1:0] base;
    sh    = shift_of(lsl_cfg);
    align = ~((AddrW'(1) << sh) - 1);
    base  = rand_addr() & align;
    hot_lines[0] = '0;
    hot_lines[1] = align;
    // same index, different tags
    for (int i = 2; i < 6; i++) begin
      hot_lines[i] = base + (AddrW'(i) << (sh + IDX_BITS));
    end
    for (int i = 6; i < 16; i++) begin
      hot_lines[i] = rand_addr() & align;
    end
  endtask

  task automatic queue_random(input int unsigned n);
    int unsigned      sh;
    int unsigned      r;
    logic [AddrW-1:0] step;
    logic [AddrW-1:0] a;
    sh   = shift_of(lsl_cfg);
    step = AddrW'(1) << sh;
    for (int unsigned k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 38) begin
        cur_line = cur_line + step;
        push_line(KindFetch, cur_line);
      end else if (r < 52) begin
        cur_line = hot_lines[$urandom_range(0, 15)];
        if ($urandom_range(0, 3) == 0) cur_line = cur_line + AddrW'($urandom_range(0, (1 << sh) - 1));
        push_line(KindFetch, cur_line);
      end else if (r < 55) begin
        push_line(KindFetch, cur_line);
      end else if (r < 84) begin
        a = $urandom_range(0, 1) ? hot_lines[$urandom_range(0, 15)] : cur_line;
        if ($urandom_range(0, 3) == 0) a = a + AddrW'($urandom_range(0, (1 << sh) - 1));
        push_line(KindPredict, a);
      end else if (r < 93) begin
        push_line(KindPredict, rand_addr());
      end else begin
        cur_line = rand_addr();
        push_line(KindFetch, cur_line);
      end
    end
  endtask

  // wait for every transaction to be taken and every result to arrive
  task automatic settle();
    while (lines_taken != lines_sent || next_line_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CfgStraightLine) straight_mode = val[0];
    else lsl_cfg = LslW'(val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // input side: sample acceptance, then offer the next transaction
  always @(posedge clk_i) begin
    in_took = 1'b0;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      in_took = 1'b1;
      lines_taken++;
      advance_line_table('{kind: kind_i, addr: line_addr_i});
    end
  end

  always @(negedge clk_i) begin : drive_lines
    line_req_t nxt;
    if (rst_ni && (!in_valid_i || in_took)) begin
      if (fetch_stream_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = fetch_stream_q[0];
        fetch_stream_q.delete(0);
        in_valid_i  <= 1'b1;
        kind_i      <= nxt.kind;
        line_addr_i <= nxt.addr;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output side stall, with a long hold when kicked
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (hold_kick != hold_ack) begin
      hold_ack    <= hold_kick;
      hold_left   <= HOLD_LEN;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : check_lines
    line_pred_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (next_line_q.size() == 0) begin
        if (mismatch_cnt < 10) begin
          $display("unexpected result transaction: predicted_addr %h table_hit %b",
                   predicted_addr_o, table_hit_o);
        end
        mismatch_cnt++;
      end else begin
        want = next_line_q[0];
        next_line_q.delete(0);
        if (want.addr !== predicted_addr_o || want.hit !== table_hit_o) begin
          if (mismatch_cnt < 10) begin
            if (want.addr !== predicted_addr_o)
              $display("predicted_addr mismatch: expected %h, got %h",
                       want.addr, predicted_addr_o);
            if (want.hit !== table_hit_o)
              $display("table_hit mismatch for %h: expected %b, got %b",
                       want.addr, want.hit, table_hit_o);
          end
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : run_phases
    bit                cfg_straight [N_PHASES];
    logic [LslW-1:0]   cfg_lsl      [N_PHASES];
    int unsigned       n_rand;
    last_line     = '0;
    straight_mode = 1'b0;
    lsl_cfg       = LslW'(LslRst);
    foreach (tag_tbl[i]) begin
      tag_tbl[i] = '0;
      tgt_tbl[i] = '0;
    end
    cfg_straight = '{0, 0, 1, 0, 0, 1, 0, 0, 0};
    cfg_lsl      = '{6, 2, 6, 8, 0, 15, 15, 3, 6};

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 30;
    recv_idle_pct = 78;

    // reset configuration, empty table
    push_line(KindPredict, 48'h0);              // all tags zero: line 0 hits
    push_line(KindPredict, 48'hFFFF_FFFF_FFFF); // next line wraps
    push_line(KindPredict, 48'h3F);             // unaligned, still tag 0
    push_line(KindFetch,   48'h0);              // same line as last fetch
    push_line(KindFetch,   48'h1000);
    push_line(KindPredict, 48'h0);
    push_line(KindFetch,   48'h1040);
    push_line(KindFetch,   48'h5000);
    push_line(KindPredict, 48'h1040);
    push_line(KindPredict, 48'h1041);
    push_line(KindFetch,   48'h1040);
    push_line(KindFetch,   48'h1080);           // sequential step clears the tag
    push_line(KindPredict, 48'h1040);
    push_line(KindFetch,   48'h0);
    push_line(KindFetch,   48'h40);
    push_line(KindPredict, 48'h0);
    push_line(KindFetch,   48'h41);
    push_line(KindFetch,   48'h81);             // unaligned sequential step
    push_line(KindPredict, 48'h40);             // cleared tag, no hit
    push_line(KindFetch,   48'hFFFF_FFFF_FFC0);
    push_line(KindFetch,   48'h0);              // wrap is not sequential
    push_line(KindPredict, 48'hFFFF_FFFF_FFC0);
    push_line(KindFetch,   48'hFFFF_FFFF_FFFF);
    push_line(KindPredict, 48'hAAAA_5555_AAAA);
    push_line(KindPredict, 48'h5555_AAAA_5555);
    cur_line = 48'hFFFF_FFFF_FFFF;

    for (int p = 0; p < N_PHASES; p++) begin
      if (p == 3) begin
        send_idle_pct = 78;
        recv_idle_pct = 30;
      end else if (p == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p != 0) begin
        settle();
        write_reg(CfgStraightLine, {CfgDataW'($urandom_range(0, 7)) << 1} | CfgDataW'(cfg_straight[p]));
        write_reg(CfgLineSizeLog2, CfgDataW'(cfg_lsl[p]));
      end
      pick_hot_lines();
      n_rand = (p == 0) ? 200 : 175;
      if (p == 6) hold_kick = ~hold_kick;
      if (p == 4) begin
        // sender waits for every result in the middle of the phase
        queue_random(n_rand / 2);
        settle();
        queue_random(n_rand - n_rand / 2);
      end else begin
        queue_random(n_rand);
      end
    end

    settle();
    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0 && next_line_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
